[sv/cbdc_pkg.sv]
package cbdc_pkg;

    // bus commands
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // selected device codes
    typedef enum logic [3:0] {
        DEV_NONE    = 4'd0,
        DEV_RAM     = 4'd1,
        DEV_PPU     = 4'd2,
        DEV_APU     = 4'd3,
        DEV_PAD1    = 4'd4,
        DEV_PAD2    = 4'd5,
        DEV_STROBE  = 4'd6,
        DEV_CART    = 4'd7,
        DEV_DMAPAGE = 4'd8
    } t_dev;

    // address map
    localparam logic [15:0] ADDR_RAM_END    = 16'h1FFF;
    localparam logic [15:0] ADDR_PPU_END    = 16'h3FFF;
    localparam logic [15:0] ADDR_APU_LO     = 16'h4000;
    localparam logic [15:0] ADDR_APU_HI     = 16'h4013;
    localparam logic [15:0] ADDR_DMA_PAGE   = 16'h4014;
    localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
    localparam logic [15:0] ADDR_PAD1       = 16'h4016;
    localparam logic [15:0] ADDR_PAD2       = 16'h4017;
    localparam logic [15:0] ADDR_CART_LO    = 16'h4020;

    // configuration register indexes and reset values
    localparam logic       REG_NUMERATOR   = 1'b0;
    localparam logic       REG_DENOMINATOR = 1'b1;
    localparam logic [4:0] NUM_RESET       = 5'd1;
    localparam logic [4:0] DEN_RESET       = 5'd3;
    localparam logic [4:0] ACC_MAX         = 5'd31;

    // result of an address decode
    typedef struct packed {
        t_dev        dev;
        logic [15:0] daddr;
        logic        is_ram;
    } t_dec;

endpackage

[sv/cbdc_in_if.sv]
interface cbdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  ext_read_data;
    logic        cart_hit;
    logic        instr_complete;
    logic        nmi_request;
    logic        irq_level;

    modport source (
        output valid, command, address, write_data, ext_read_data,
               cart_hit, instr_complete, nmi_request, irq_level,
        input  ready
    );
    modport sink (
        input  valid, command, address, write_data, ext_read_data,
               cart_hit, instr_complete, nmi_request, irq_level,
        output ready
    );
endinterface

[sv/cbdc_out_if.sv]
interface cbdc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  device;
    logic [15:0] device_address;
    logic        device_write;
    logic [7:0]  bus_data;
    logic        cpu_step;
    logic        apu_step;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        nmi_deliver;
    logic        irq_deliver;

    modport source (
        output valid, device, device_address, device_write, bus_data, cpu_step,
               apu_step, oam_write, oam_index, oam_data, nmi_deliver, irq_deliver,
        input  ready
    );
    modport sink (
        input  valid, device, device_address, device_write, bus_data, cpu_step,
               apu_step, oam_write, oam_index, oam_data, nmi_deliver, irq_deliver,
        output ready
    );
endinterface

[sv/cbdc_bus_decode.sv]
module cbdc_bus_decode
    import cbdc_pkg::*;
#(
    parameter int RAM_ADDR_BITS = 11
) (
    input  logic        i_write,
    input  logic [15:0] i_addr,
    input  logic        i_cart_hit,
    output t_dec        o_dec
);

    logic is_apu_wr;

    // registers the sound unit takes on a write
    assign is_apu_wr = ((i_addr >= ADDR_APU_LO) && (i_addr <= ADDR_APU_HI))
                    || (i_addr == ADDR_APU_STATUS) || (i_addr == ADDR_PAD2);

    // device select
    always_comb begin
        o_dec.is_ram = (i_addr <= ADDR_RAM_END);
        priority if (i_addr <= ADDR_RAM_END) begin
            o_dec.dev = DEV_RAM;
        end else if (i_addr <= ADDR_PPU_END) begin
            o_dec.dev = DEV_PPU;
        end else if (i_write) begin
            priority if (i_addr == ADDR_DMA_PAGE) begin
                o_dec.dev = DEV_DMAPAGE;
            end else if (i_addr == ADDR_PAD1) begin
                o_dec.dev = DEV_STROBE;
            end else if (is_apu_wr) begin
                o_dec.dev = DEV_APU;
            end else if (i_addr >= ADDR_CART_LO) begin
                o_dec.dev = DEV_CART;
            end else begin
                o_dec.dev = DEV_NONE;
            end
        end else begin
            priority if (i_addr == ADDR_APU_STATUS) begin
                o_dec.dev = DEV_APU;
            end else if (i_addr == ADDR_PAD1) begin
                o_dec.dev = DEV_PAD1;
            end else if (i_addr == ADDR_PAD2) begin
                o_dec.dev = DEV_PAD2;
            end else if ((i_addr >= ADDR_CART_LO) && i_cart_hit) begin
                o_dec.dev = DEV_CART;
            end else begin
                o_dec.dev = DEV_NONE;
            end
        end

        // device address: mirrored index for ram, zero for an ignored write
        priority if (o_dec.is_ram) begin
            o_dec.daddr = {{(16 - RAM_ADDR_BITS){1'b0}}, i_addr[RAM_ADDR_BITS-1:0]};
        end else if (i_write && (o_dec.dev == DEV_NONE)) begin
            o_dec.daddr = '0;
        end else begin
            o_dec.daddr = i_addr;
        end
    end

endmodule

[sv/cbdc_wram.sv]
module cbdc_wram #(
    parameter int ADDR_BITS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [7:0]           i_wdata,
    output logic [7:0]           o_rdata
);

    localparam int Depth = 1 << ADDR_BITS;

    logic [7:0] r_mem [Depth];
    logic [7:0] r_rdata;

    // single port work ram, read data registered and held between reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/cbdc_clkdiv.sv]
module cbdc_clkdiv
    import cbdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_step,
    output logic        o_rate_tick
);

    logic [4:0] r_num;
    logic [4:0] r_den;
    logic [4:0] r_acc;
    logic [4:0] n_acc;
    logic [5:0] sum;
    logic [5:0] rem;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register readback
    assign prdata = (paddr[2] == REG_DENOMINATOR) ? {27'd0, r_den} : {27'd0, r_num};

    // fractional accumulator: one cpu rate cycle each time the sum reaches the threshold
    always_comb begin
        sum         = {1'b0, r_acc} + {1'b0, r_num};
        o_rate_tick = (sum >= {1'b0, r_den});
        rem         = o_rate_tick ? (sum - {1'b0, r_den}) : sum;
        n_acc       = (rem > {1'b0, ACC_MAX}) ? ACC_MAX : rem[4:0];
    end

    // config registers and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NUM_RESET;
            r_den <= DEN_RESET;
            r_acc <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NUMERATOR) begin
                r_num <= pwdata[4:0];
            end else begin
                r_den <= pwdata[4:0];
            end
            r_acc <= '0;
        end else if (i_step) begin
            r_acc <= n_acc;
        end
    end

endmodule

[sv/console_bus_clock_dma_controller.sv]
// Console bus controller with sprite memory DMA.
// Input channel i_in carries one command word: a cpu read or write, a ppu
// clock tick or a nop. Output channel o_out returns exactly one result word
// per command: decoded device, device address, data, step enables, sprite
// memory write and interrupt delivery. Both are valid/ready channels.
// The APB port holds the clock ratio numerator (0x0) and denominator (0x4);
// a write to either clears the tick accumulator. Write it only while idle.
// An accepted word's result is registered and shows from the next edge on.
// Intake is one word per cycle unless results stall; the only stage is the
// result register, loaded from the input fields through one decode and the
// accumulator add/compare. Work ram read data comes from the ram's own
// output register, which loads at the same edge as the result register.
// Input ready stays high while the result register is empty or being taken,
// so a stalled receiver holds the result and stops intake after one word.
// Reset (synchronous, active low) restores the ratio to 1/3, clears the
// accumulator, parity and DMA state. Work ram is not cleared; reading a
// byte never written returns an unspecified value.
module console_bus_clock_dma_controller
    import cbdc_pkg::*;
#(
    parameter int RAM_ADDR_BITS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbdc_in_if.sink     i_in,
    cbdc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // dma and parity state
    logic       r_dma_active;
    logic       r_align_wait;
    logic       r_parity;
    logic [7:0] r_dma_page;
    logic [7:0] r_dma_index;
    logic [7:0] r_latch;
    logic       r_latch_ram;

    // result register
    logic        r_out_valid;
    t_dev        r_dev;
    logic [15:0] r_daddr;
    logic        r_dwr;
    logic [7:0]  r_data;
    logic        r_data_ram;
    logic        r_cstep;
    logic        r_astep;
    logic        r_ow;
    logic [7:0]  r_oi;
    logic [7:0]  r_od;
    logic        r_nd;
    logic        r_id;

    logic        accept;
    t_cmd        cmd;
    logic        is_read;
    logic        is_write;
    logic        is_tick;
    logic        rate_tick;
    logic        cpu_cycle;
    logic        dma_fetch;
    logic        dma_wr;
    logic        show_dev;
    logic [15:0] dec_addr;
    t_dec        dec;
    logic [7:0]  ext_data;
    logic [7:0]  eff_latch;
    logic [7:0]  ram_q;
    logic        ram_rd;
    logic        ram_wr;

    assign cmd      = t_cmd'(i_in.command);
    assign is_read  = (cmd == CMD_READ);
    assign is_write = (cmd == CMD_WRITE);
    assign is_tick  = (cmd == CMD_TICK);

    // handshake: output register frees as it is taken
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // clock ratio and config
    cbdc_clkdiv u_clkdiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_step      (accept && is_tick),
        .o_rate_tick (rate_tick)
    );

    // dma phase of this tick
    assign cpu_cycle = is_tick && rate_tick;
    assign dma_fetch = cpu_cycle && r_dma_active && !r_align_wait && !r_parity;
    assign dma_wr    = cpu_cycle && r_dma_active && !r_align_wait && r_parity;

    // one decoder serves cpu accesses and dma fetches
    assign dec_addr = is_tick ? {r_dma_page, r_dma_index} : i_in.address;

    cbdc_bus_decode #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_decode (
        .i_write    (is_write),
        .i_addr     (dec_addr),
        .i_cart_hit (i_in.cart_hit),
        .o_dec      (dec)
    );

    // work ram
    assign ram_rd = accept && (is_read || dma_fetch) && dec.is_ram;
    assign ram_wr = accept && is_write && dec.is_ram;

    cbdc_wram #(
        .ADDR_BITS (RAM_ADDR_BITS)
    ) u_wram (
        .i_clk   (i_clk),
        .i_wr_en (ram_wr),
        .i_rd_en (ram_rd),
        .i_addr  (dec.daddr[RAM_ADDR_BITS-1:0]),
        .i_wdata (i_in.write_data),
        .o_rdata (ram_q)
    );

    // data from a non-ram device, open bus reads zero
    assign ext_data  = (dec.dev == DEV_NONE) ? 8'd0 : i_in.ext_read_data;
    // fetched byte may still sit in the ram output register
    assign eff_latch = r_latch_ram ? ram_q : r_latch;
    assign show_dev  = is_read || is_write || dma_fetch;

    // dma and parity state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_active <= 1'b0;
            r_align_wait <= 1'b1;
            r_parity     <= 1'b0;
            r_dma_page   <= '0;
            r_dma_index  <= '0;
            r_latch      <= '0;
            r_latch_ram  <= 1'b0;
        end else if (accept) begin
            if (dma_fetch) begin
                r_latch     <= ext_data;
                r_latch_ram <= dec.is_ram;
            end else begin
                r_latch     <= eff_latch;
                r_latch_ram <= 1'b0;
            end
            if (is_write && (dec.dev == DEV_DMAPAGE)) begin
                r_dma_page   <= i_in.write_data;
                r_dma_index  <= '0;
                r_dma_active <= 1'b1;
            end
            if (cpu_cycle) begin
                r_parity <= !r_parity;
                if (r_dma_active && r_align_wait && r_parity) begin
                    r_align_wait <= 1'b0;
                end
            end
            if (dma_wr) begin
                r_dma_index <= r_dma_index + 8'd1;
                if (r_dma_index == 8'hFF) begin
                    r_dma_active <= 1'b0;
                    r_align_wait <= 1'b1;
                end
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dev      <= show_dev ? dec.dev : DEV_NONE;
            r_daddr    <= show_dev ? dec.daddr : 16'd0;
            r_dwr      <= is_write && (dec.dev != DEV_NONE);
            r_data_ram <= (is_read || dma_fetch) && dec.is_ram;
            if (is_write) begin
                r_data <= (dec.dev == DEV_NONE) ? 8'd0 : i_in.write_data;
            end else if (is_read || dma_fetch) begin
                r_data <= ext_data;
            end else begin
                r_data <= '0;
            end
            r_cstep <= cpu_cycle && !r_dma_active;
            r_astep <= cpu_cycle;
            r_ow    <= dma_wr;
            r_oi    <= dma_wr ? r_dma_index : 8'd0;
            r_od    <= dma_wr ? eff_latch : 8'd0;
            r_nd    <= is_tick && i_in.instr_complete && i_in.nmi_request;
            r_id    <= is_tick && i_in.instr_complete && i_in.irq_level;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.device         = r_dev;
    assign o_out.device_address = r_daddr;
    assign o_out.device_write   = r_dwr;
    assign o_out.bus_data       = r_data_ram ? ram_q : r_data;
    assign o_out.cpu_step       = r_cstep;
    assign o_out.apu_step       = r_astep;
    assign o_out.oam_write      = r_ow;
    assign o_out.oam_index      = r_oi;
    assign o_out.oam_data       = r_od;
    assign o_out.nmi_deliver    = r_nd;
    assign o_out.irq_deliver    = r_id;

    // checks
    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_cstep && r_ow))
        else $error("cpu step and dma write in one cycle");

    a_apu_with_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_cstep || r_ow)) |-> r_astep)
        else $error("cpu rate cycle without apu step");

    a_idle_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dma_active |-> r_align_wait)
        else $error("dma idle without alignment wait");

    a_write_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dwr) |-> (r_dev != DEV_NONE))
        else $error("device write with no device");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_daddr)))
        else $error("stalled result lost");

endmodule

[test/testbench.sv]
module testbench;
    import cbdc_pkg::*;

    localparam int          RAM_BITS    = 11;
    localparam int          RAM_WORDS   = 1 << RAM_BITS;
    localparam logic [15:0] RAM_MASK    = 16'(RAM_WORDS - 1);
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          SETTLE      = 4;

    // one command word as driven on the input channel
    typedef struct packed {
        t_cmd        command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  ext_read_data;
        logic        cart_hit;
        logic        instr_complete;
        logic        nmi_request;
        logic        irq_level;
    } t_bus_cmd;

    // one result word as seen on the output channel
    typedef struct packed {
        t_dev        device;
        logic [15:0] device_address;
        logic        device_write;
        logic [7:0]  bus_data;
        logic        cpu_step;
        logic        apu_step;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        nmi_deliver;
        logic        irq_deliver;
    } t_bus_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cbdc_in_if  cmd_if ();
    cbdc_out_if res_if ();

    console_bus_clock_dma_controller #(
        .RAM_ADDR_BITS(RAM_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the bus controller state
    logic [7:0] ram_image   [RAM_WORDS];
    bit         ram_written [RAM_WORDS];
    logic [4:0] ratio_num;
    logic [4:0] ratio_den;
    logic [4:0] tick_acc;
    logic       odd_cycle;
    logic       dma_busy;
    logic       dma_align;
    logic [7:0] dma_page_q;
    logic [7:0] dma_idx;
    logic [7:0] dma_byte;

    t_bus_res   expected_results [$];
    t_bus_res   exp_word;
    int         fail_count;
    int         cycle_count;
    bit         gaps_on;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // read decode shared by cpu reads and dma fetches
    function automatic logic [7:0] fetch_decode(input logic [15:0] addr, input logic [7:0] ext,
                                                input logic hit, output t_dev dev,
                                                output logic [15:0] daddr);
        daddr = addr;
        if (addr <= ADDR_RAM_END) begin
            dev   = DEV_RAM;
            daddr = addr & RAM_MASK;
            return ram_image[addr[RAM_BITS-1:0]];
        end
        if (addr <= ADDR_PPU_END) begin
            dev = DEV_PPU;
            return ext;
        end
        if (addr == ADDR_APU_STATUS) begin
            dev = DEV_APU;
            return ext;
        end
        if (addr == ADDR_PAD1) begin
            dev = DEV_PAD1;
            return ext;
        end
        if (addr == ADDR_PAD2) begin
            dev = DEV_PAD2;
            return ext;
        end
        if (addr >= ADDR_CART_LO && hit) begin
            dev = DEV_CART;
            return ext;
        end
        dev = DEV_NONE;
        return 8'h00;
    endfunction

    // expected result of one word, advancing the shadow state
    function automatic t_bus_res bus_predict(input t_bus_cmd w);
        t_bus_res r;
        int       sum;
        bit       cpu_cycle;
        t_dev     dev;
        r = '0;
        unique case (w.command)
            CMD_READ: begin
                r.bus_data = fetch_decode(w.address, w.ext_read_data, w.cart_hit, dev,
                                          r.device_address);
                r.device = dev;
            end
            CMD_WRITE: begin
                r.device_address = w.address;
                r.bus_data       = w.write_data;
                if (w.address <= ADDR_RAM_END) begin
                    r.device         = DEV_RAM;
                    r.device_address = w.address & RAM_MASK;
                    ram_image[w.address[RAM_BITS-1:0]]   = w.write_data;
                    ram_written[w.address[RAM_BITS-1:0]] = 1'b1;
                end else if (w.address <= ADDR_PPU_END) begin
                    r.device = DEV_PPU;
                end else if (w.address == ADDR_DMA_PAGE) begin
                    r.device   = DEV_DMAPAGE;
                    dma_page_q = w.write_data;
                    dma_idx    = 8'h00;
                    dma_busy   = 1'b1;
                end else if (w.address == ADDR_PAD1) begin
                    r.device = DEV_STROBE;
                end else if ((w.address >= ADDR_APU_LO && w.address <= ADDR_APU_HI) ||
                             w.address == ADDR_APU_STATUS || w.address == ADDR_PAD2) begin
                    r.device = DEV_APU;
                end else if (w.address >= ADDR_CART_LO) begin
                    r.device = DEV_CART;
                end else begin
                    r.device         = DEV_NONE;
                    r.device_address = '0;
                    r.bus_data       = '0;
                end
                r.device_write = (r.device != DEV_NONE);
            end
            CMD_TICK: begin
                sum       = int'(tick_acc) + int'(ratio_num);
                cpu_cycle = (sum >= int'(ratio_den));
                if (cpu_cycle)
                    sum -= int'(ratio_den);
                tick_acc = (sum > int'(ACC_MAX)) ? ACC_MAX : 5'(sum);
                if (cpu_cycle) begin
                    r.apu_step = 1'b1;
                    if (dma_busy) begin
                        if (dma_align) begin
                            // hold until an odd cycle lines the transfer up
                            if (odd_cycle)
                                dma_align = 1'b0;
                        end else if (!odd_cycle) begin
                            dma_byte   = fetch_decode({dma_page_q, dma_idx}, w.ext_read_data,
                                                      w.cart_hit, dev, r.device_address);
                            r.device   = dev;
                            r.bus_data = dma_byte;
                        end else begin
                            r.oam_write = 1'b1;
                            r.oam_index = dma_idx;
                            r.oam_data  = dma_byte;
                            dma_idx     = dma_idx + 8'd1;
                            if (dma_idx == 8'h00) begin
                                dma_busy  = 1'b0;
                                dma_align = 1'b1;
                            end
                        end
                    end else begin
                        r.cpu_step = 1'b1;
                    end
                    odd_cycle = ~odd_cycle;
                end
                r.nmi_deliver = w.instr_complete & w.nmi_request;
                r.irq_deliver = w.instr_complete & w.irq_level;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] expv,
                                        input logic [15:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0h actual %0h", name, expv, actv);
            fail_count++;
        end
    endfunction

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result word with no prediction pending");
                fail_count++;
            end else begin
                exp_word = expected_results.pop_front();
                check_field("device", 16'(exp_word.device), 16'(res_if.device));
                check_field("device_address", exp_word.device_address,
                            res_if.device_address);
                check_field("device_write", 16'(exp_word.device_write),
                            16'(res_if.device_write));
                check_field("bus_data", 16'(exp_word.bus_data), 16'(res_if.bus_data));
                check_field("cpu_step", 16'(exp_word.cpu_step), 16'(res_if.cpu_step));
                check_field("apu_step", 16'(exp_word.apu_step), 16'(res_if.apu_step));
                check_field("oam_write", 16'(exp_word.oam_write), 16'(res_if.oam_write));
                check_field("oam_index", 16'(exp_word.oam_index), 16'(res_if.oam_index));
                check_field("oam_data", 16'(exp_word.oam_data), 16'(res_if.oam_data));
                check_field("nmi_deliver", 16'(exp_word.nmi_deliver),
                            16'(res_if.nmi_deliver));
                check_field("irq_deliver", 16'(exp_word.irq_deliver),
                            16'(res_if.irq_deliver));
            end
        end
    end

    // receiver stalls in random bursts
    initial begin : result_ready_gen
        int stall_left;
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                res_if.ready = 1'b0;
                stall_left   = $urandom_range(0, 8);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // command word with random side fields
    function automatic t_bus_cmd word_of(input t_cmd cmd, input logic [15:0] addr,
                                         input logic [7:0] data);
        t_bus_cmd w;
        w.command        = cmd;
        w.address        = addr;
        w.write_data     = data;
        w.ext_read_data  = 8'($urandom_range(0, 255));
        w.cart_hit       = 1'($urandom_range(0, 1));
        w.instr_complete = 1'($urandom_range(0, 1));
        w.nmi_request    = 1'($urandom_range(0, 1));
        w.irq_level      = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic bit ram_page_full(input logic [2:0] pg);
        for (int i = 0; i < 256; i++)
            if (!ram_written[{pg, 8'(i)}])
                return 1'b0;
        return 1'b1;
    endfunction

    // dma page that never fetches unwritten ram
    function automatic logic [7:0] pick_dma_page();
        logic [7:0] pg;
        case ($urandom_range(0, 3))
            0:       pg = 8'($urandom_range(0, 8'h1F));
            1:       pg = 8'h40;
            2:       pg = 8'($urandom_range(8'h20, 8'h3F));
            default: pg = 8'($urandom_range(8'h41, 8'hFF));
        endcase
        if (pg <= 8'h1F && !ram_page_full(pg[2:0]))
            pg = 8'h40;
        return pg;
    endfunction

    // drive one word and record its prediction once accepted
    task automatic send_word(input t_bus_cmd w);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            cmd_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        cmd_if.valid          = 1'b1;
        cmd_if.command        = w.command;
        cmd_if.address        = w.address;
        cmd_if.write_data     = w.write_data;
        cmd_if.ext_read_data  = w.ext_read_data;
        cmd_if.cart_hit       = w.cart_hit;
        cmd_if.instr_complete = w.instr_complete;
        cmd_if.nmi_request    = w.nmi_request;
        cmd_if.irq_level      = w.irq_level;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        expected_results.push_back(bus_predict(w));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        cmd_if.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // write a ratio register over apb, then read it back
    task automatic write_ratio(input logic idx, input logic [4:0] value);
        drain_results();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = {27'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_NUMERATOR)
            ratio_num = value;
        else
            ratio_den = value;
        tick_acc = '0;
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== {27'd0, value}) begin
            $error("prdata: expected %0h actual %0h", {27'd0, value}, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_ratio(input logic [4:0] num, input logic [4:0] den);
        write_ratio(REG_NUMERATOR, num);
        write_ratio(REG_DENOMINATOR, den);
    endtask

    // address map edges, every command, interrupt gating
    task automatic test_address_map();
        t_bus_cmd w;
        send_word(word_of(CMD_WRITE, 16'h0000, 8'h00));
        send_word(word_of(CMD_WRITE, 16'h07FF, 8'hFF));
        send_word(word_of(CMD_WRITE, 16'h1FFF, 8'hA5));
        send_word(word_of(CMD_WRITE, 16'h2000, 8'h12));
        send_word(word_of(CMD_WRITE, 16'h3FFF, 8'hFF));
        send_word(word_of(CMD_WRITE, ADDR_APU_LO, 8'h3C));
        send_word(word_of(CMD_WRITE, ADDR_APU_HI, 8'hC3));
        send_word(word_of(CMD_WRITE, ADDR_APU_STATUS, 8'h0F));
        send_word(word_of(CMD_WRITE, ADDR_PAD1, 8'h01));
        send_word(word_of(CMD_WRITE, ADDR_PAD2, 8'h40));
        send_word(word_of(CMD_WRITE, 16'h401F, 8'h77));
        send_word(word_of(CMD_WRITE, ADDR_CART_LO, 8'h5A));
        send_word(word_of(CMD_WRITE, 16'hFFFF, 8'hFF));
        // mirrored ram reads of bytes written above
        send_word(word_of(CMD_READ, 16'h0800, 8'h00));
        send_word(word_of(CMD_READ, 16'h07FF, 8'h00));
        w = word_of(CMD_READ, ADDR_DMA_PAGE, 8'h00);
        w.ext_read_data = 8'hFF;
        send_word(w);
        send_word(word_of(CMD_READ, ADDR_APU_STATUS, 8'h00));
        send_word(word_of(CMD_READ, ADDR_PAD1, 8'h00));
        send_word(word_of(CMD_READ, ADDR_PAD2, 8'h00));
        w = word_of(CMD_READ, 16'h401F, 8'h00);
        w.cart_hit = 1'b1;
        send_word(w);
        w = word_of(CMD_READ, ADDR_CART_LO, 8'h00);
        w.cart_hit = 1'b0;
        send_word(w);
        w = word_of(CMD_READ, 16'hFFFF, 8'h00);
        w.cart_hit      = 1'b1;
        w.ext_read_data = 8'h00;
        send_word(w);
        send_word(word_of(CMD_NOP, 16'hFFFF, 8'hFF));
        // interrupts pass only at an instruction boundary
        for (int k = 0; k < 4; k++) begin
            w = word_of(CMD_TICK, 16'h0000, 8'h00);
            w.instr_complete = (k != 1);
            w.nmi_request    = (k != 2);
            w.irq_level      = (k != 3);
            send_word(w);
        end
    endtask

    // accumulator over several ratios, including saturation and stalls
    task automatic test_clock_ratio();
        logic [4:0] num_set [7] = '{5'd1, 5'd5, 5'd16, 5'd31, 5'd0, 5'd16, 5'd1};
        logic [4:0] den_set [7] = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd5, 5'd16, 5'd1};
        for (int s = 0; s < 7; s++) begin
            set_ratio(num_set[s], den_set[s]);
            repeat (12) send_word(word_of(CMD_TICK, 16'($urandom_range(0, 65535)), 8'h00));
        end
    endtask

    // fill one ram page, start a dma, restart it from that page and run it out
    task automatic test_sprite_dma();
        logic [2:0] pg;
        set_ratio(5'd1, 5'd1);
        pg = 3'($urandom_range(0, 7));
        for (int k = 0; k < 256; k++)
            send_word(word_of(CMD_WRITE, {3'b000, 2'($urandom_range(0, 3)), pg, 8'(k)},
                              8'($urandom_range(0, 255))));
        send_word(word_of(CMD_WRITE, ADDR_DMA_PAGE, 8'h40));
        repeat (70) send_word(word_of(CMD_TICK, 16'($urandom_range(0, 65535)), 8'h00));
        send_word(word_of(CMD_WRITE, ADDR_DMA_PAGE, {3'b000, 2'($urandom_range(0, 3)), pg}));
        while (dma_busy)
            send_word(word_of(CMD_TICK, 16'($urandom_range(0, 65535)), 8'h00));
    endtask

    // mixed traffic with occasional dma starts
    task automatic run_random_mix(input int count);
        t_bus_cmd    w;
        logic [15:0] addr;
        int          pick;
        t_cmd        cmd;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 4))
                0:       addr = 16'($urandom_range(0, 16'h1FFF));
                1:       addr = 16'($urandom_range(16'h2000, 16'h3FFF));
                2:       addr = 16'($urandom_range(16'h4000, 16'h401F));
                3:       addr = 16'($urandom_range(16'h4020, 16'hFFFF));
                default: addr = 16'($urandom_range(0, 16'hFFFF));
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 9)
                cmd = CMD_TICK;
            else if (pick < 13)
                cmd = CMD_READ;
            else if (pick < 19)
                cmd = CMD_WRITE;
            else
                cmd = CMD_NOP;
            // an unwritten ram byte is written instead of read
            if (cmd == CMD_READ && addr <= ADDR_RAM_END && !ram_written[addr[RAM_BITS-1:0]])
                cmd = CMD_WRITE;
            if ($urandom_range(0, 299) == 0) begin
                cmd  = CMD_WRITE;
                addr = ADDR_DMA_PAGE;
            end
            w = word_of(cmd, addr, 8'($urandom_range(0, 255)));
            if (cmd == CMD_WRITE && addr == ADDR_DMA_PAGE)
                w.write_data = pick_dma_page();
            send_word(w);
        end
    endtask

    task automatic test_random_traffic();
        set_ratio(5'd1, 5'd3);
        run_random_mix(250);
        set_ratio(5'd5, 5'd16);
        run_random_mix(250);
        set_ratio(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)));
        run_random_mix(250);
        // closing stretch at full rate on both sides
        set_ratio(5'd16, 5'd1);
        gaps_on = 1'b0;
        run_random_mix(250);
    endtask

    // reset, tests in turn, final verdict
    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        cmd_if.valid          = 1'b0;
        cmd_if.command        = CMD_NOP;
        cmd_if.address        = '0;
        cmd_if.write_data     = '0;
        cmd_if.ext_read_data  = '0;
        cmd_if.cart_hit       = 1'b0;
        cmd_if.instr_complete = 1'b0;
        cmd_if.nmi_request    = 1'b0;
        cmd_if.irq_level      = 1'b0;
        fail_count            = 0;
        cycle_count           = 0;
        gaps_on               = 1'b1;
        for (int i = 0; i < RAM_WORDS; i++) begin
            ram_image[i]   = '0;
            ram_written[i] = 1'b0;
        end
        ratio_num  = NUM_RESET;
        ratio_den  = DEN_RESET;
        tick_acc   = '0;
        odd_cycle  = 1'b0;
        dma_busy   = 1'b0;
        dma_align  = 1'b1;
        dma_page_q = '0;
        dma_idx    = '0;
        dma_byte   = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_address_map();
        test_clock_ratio();
        test_sprite_dma();
        test_random_traffic();

        drain_results();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
